[rtl/core/fsft_pkg.sv]
// Shared types and constants of the fixed-step frame timer.
package fsft_pkg;

    localparam int STAMP_W  = 64;
    localparam int CFG_W    = 32;
    localparam int SCALE_W  = 16;
    localparam int STEPS_W  = 7;
    localparam int DT_W     = 32;
    localparam int FRAMES_W = 32;
    localparam int FPS_W    = 24;
    localparam int ACC_W    = 48;
    localparam int CAP_W    = 47;
    localparam int WT_W     = 40;
    localparam int REM_W    = WT_W + 1;
    localparam int PROD_W   = 64;
    localparam int REQ_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam int DIV_STEPS = FPS_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [FPS_W-1:0]    FPS_MAX    = '1;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX = '1;

    localparam logic [CFG_W-1:0]   RST_COUNTER_HZ = 32'd10000000;
    localparam logic [CFG_W-1:0]   RST_FIXED_STEP = 32'd166667;
    localparam logic [SCALE_W-1:0] RST_TIME_SCALE = 16'd256;
    localparam logic [CFG_W-1:0]   RST_MAX_DT     = 32'd2500000;
    localparam logic [STEPS_W-1:0] RST_MAX_STEPS  = 7'd8;

    typedef enum logic [REQ_W-1:0] {
        REQ_START   = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_CONSUME = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNTER_HZ = 3'd0,
        CFG_FIXED_STEP = 3'd1,
        CFG_TIME_SCALE = 3'd2,
        CFG_MAX_DT     = 3'd3,
        CFG_MAX_STEPS  = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL_CAP,
        ST_MUL_ACC,
        ST_ACC,
        ST_MUL_RATE,
        ST_RATE_CHK,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

[rtl/core/fixed_step_frame_timer.sv]
// Fixed-step frame timer: sequencer around one shared multiplier and a serial divider.
// One item is taken at a time. A start or consume request passes through the execute state to
// the output state. A frame tick passes on from the execute state through the cap multiply, the
// scaled-delta multiply and the accumulate states, because the step cap and the scaled delta pass
// one after another through the single 32x32 multiplier. When half a second of time has gathered,
// the tick also forms the frames-times-rate product and checks it; when the rate saturates it goes
// straight to the output, otherwise the restoring divider follows. Input stall stays high from
// acceptance until the result item has been taken, so output stall lengthens the occupancy.
// Configuration writes are always ready and take effect at once.
module fixed_step_frame_timer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [fsft_pkg::REQ_W-1:0]       i_req_type,
    input  logic [fsft_pkg::STAMP_W-1:0]     i_timestamp,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [fsft_pkg::DT_W-1:0]        o_frame_dt_ticks,
    output logic [fsft_pkg::STAMP_W-1:0]     o_total_ticks,
    output logic [fsft_pkg::FRAMES_W-1:0]    o_frame_number,
    output logic [fsft_pkg::FPS_W-1:0]       o_fps_value,
    output logic                             o_step_granted,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fsft_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fsft_pkg::CFG_W-1:0]       i_cfg_data
);
    import fsft_pkg::*;

    // Configuration
    logic [CFG_W-1:0]   r_hz;
    logic [CFG_W-1:0]   r_fixed;
    logic [SCALE_W-1:0] r_scale;
    logic [CFG_W-1:0]   r_max_dt;
    logic [STEPS_W-1:0] r_max_steps;

    // Timer state
    t_state              r_state, n_state;
    logic [STAMP_W-1:0]  r_last, n_last;
    logic [STAMP_W-1:0]  r_total, n_total;
    logic [FRAMES_W-1:0] r_frames, n_frames;
    logic [ACC_W-1:0]    r_accum, n_accum;
    logic [WT_W-1:0]     r_wticks, n_wticks;
    logic [FRAMES_W-1:0] r_wframes, n_wframes;
    logic [FPS_W-1:0]    r_fps, n_fps;
    logic [DT_W-1:0]     r_dt, n_dt;
    logic                r_granted, n_granted;

    // Working registers
    logic [REQ_W-1:0]     r_req, n_req;
    logic [STAMP_W-1:0]   r_stamp, n_stamp;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [CAP_W-1:0]     r_cap, n_cap;
    logic [REM_W-1:0]     r_rem, n_rem;
    logic [FPS_W-1:0]     r_dq, n_dq;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;

    logic                 w_in_acc;
    logic                 w_out_acc;
    logic [CFG_W-1:0]     w_mul_a;
    logic [CFG_W-1:0]     w_mul_b;
    logic [PROD_W-1:0]    w_mul_p;
    logic [STAMP_W-1:0]   w_diff;
    logic [DT_W-1:0]      w_delta;
    logic [ACC_W:0]       w_acc_sum;
    logic [ACC_W-1:0]     w_step;
    logic                 w_fps_due;
    logic                 w_rate_sat;
    logic [REM_W-1:0]     w_shift;
    logic [REM_W-1:0]     w_divisor;
    logic                 w_ge;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // The one multiplier of the block.
    assign w_mul_p = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // A timestamp behind the last one (as a signed difference) counts as no time.
    assign w_diff  = r_stamp - r_last;
    assign w_delta = w_diff[STAMP_W-1] ? '0 :
                     (w_diff > STAMP_W'(r_max_dt)) ? r_max_dt : w_diff[DT_W-1:0];

    assign w_acc_sum  = {1'b0, r_accum} + {1'b0, r_prod[ACC_W-1:0]};
    assign w_step     = {8'd0, r_fixed, 8'd0};
    assign w_fps_due  = {r_wticks, 1'b0} >= REM_W'(r_hz);
    assign w_rate_sat = (r_wticks == '0) || (r_prod >= {8'd0, r_wticks, 16'd0});

    assign w_divisor = {1'b0, r_wticks};
    assign w_shift   = {r_rem[REM_W-2:0], r_dq[FPS_W-1]};
    assign w_ge      = w_shift >= w_divisor;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (w_in_acc) n_state = ST_EXEC;
            ST_EXEC:     n_state = (r_req == REQ_TICK) ? ST_MUL_CAP : ST_OUT;
            ST_MUL_CAP:  n_state = ST_MUL_ACC;
            ST_MUL_ACC:  n_state = ST_ACC;
            ST_ACC:      n_state = w_fps_due ? ST_MUL_RATE : ST_OUT;
            ST_MUL_RATE: n_state = ST_RATE_CHK;
            ST_RATE_CHK: n_state = w_rate_sat ? ST_OUT : ST_DIV;
            ST_DIV:      if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = ST_OUT;
            ST_OUT:      if (!i_out_stall) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // State outputs: handshake and multiplier operand selection
    always_comb begin
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        case (r_state)
            ST_IDLE: o_in_stall = 1'b0;
            ST_MUL_CAP: begin
                w_mul_a = r_fixed;
                w_mul_b = CFG_W'(r_max_steps);
            end
            ST_MUL_ACC: begin
                w_mul_a = r_dt;
                w_mul_b = CFG_W'(r_scale);
            end
            ST_MUL_RATE: begin
                w_mul_a = r_wframes;
                w_mul_b = r_hz;
            end
            ST_OUT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    // Datapath
    always_comb begin
        n_last    = r_last;
        n_total   = r_total;
        n_frames  = r_frames;
        n_accum   = r_accum;
        n_wticks  = r_wticks;
        n_wframes = r_wframes;
        n_fps     = r_fps;
        n_dt      = r_dt;
        n_granted = r_granted;
        n_req     = r_req;
        n_stamp   = r_stamp;
        n_prod    = r_prod;
        n_cap     = r_cap;
        n_rem     = r_rem;
        n_dq      = r_dq;
        n_cnt     = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_req   = i_req_type;
                    n_stamp = i_timestamp;
                end
            end
            ST_EXEC: begin
                n_dt      = '0;
                n_granted = 1'b0;
                case (r_req)
                    REQ_START: begin
                        n_last    = r_stamp;
                        n_total   = '0;
                        n_frames  = '0;
                        n_accum   = '0;
                        n_wticks  = '0;
                        n_wframes = '0;
                        n_fps     = '0;
                    end
                    REQ_TICK: begin
                        n_last   = r_stamp;
                        n_dt     = w_delta;
                        n_total  = r_total + STAMP_W'(w_delta);
                        n_frames = r_frames + 1'b1;
                        n_wticks = r_wticks + WT_W'(w_delta);
                        if (r_wframes != FRAMES_MAX) n_wframes = r_wframes + 1'b1;
                    end
                    REQ_CONSUME: begin
                        if (r_accum >= w_step) begin
                            n_accum   = r_accum - w_step;
                            n_granted = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_MUL_CAP: n_prod = w_mul_p;
            ST_MUL_ACC: begin
                n_cap  = {r_prod[CAP_W-9:0], 8'd0};
                n_prod = w_mul_p;
            end
            ST_ACC: begin
                if (w_acc_sum > (ACC_W + 1)'(r_cap)) n_accum = ACC_W'(r_cap);
                else                                 n_accum = w_acc_sum[ACC_W-1:0];
            end
            ST_MUL_RATE: n_prod = w_mul_p;
            ST_RATE_CHK: begin
                if (w_rate_sat) begin
                    n_fps     = FPS_MAX;
                    n_wticks  = '0;
                    n_wframes = '0;
                end else begin
                    // Dividend is the product times 256; its top part already sits below
                    // the divisor, so 24 quotient bits remain.
                    n_rem = r_prod[16 +: REM_W];
                    n_dq  = {r_prod[15:0], 8'd0};
                    n_cnt = '0;
                end
            end
            ST_DIV: begin
                n_rem = w_ge ? (w_shift - w_divisor) : w_shift;
                n_dq  = {r_dq[FPS_W-2:0], w_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_fps     = {r_dq[FPS_W-2:0], w_ge};
                    n_wticks  = '0;
                    n_wframes = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hz        <= RST_COUNTER_HZ;
            r_fixed     <= RST_FIXED_STEP;
            r_scale     <= RST_TIME_SCALE;
            r_max_dt    <= RST_MAX_DT;
            r_max_steps <= RST_MAX_STEPS;
            r_last      <= '0;
            r_total     <= '0;
            r_frames    <= '0;
            r_accum     <= '0;
            r_wticks    <= '0;
            r_wframes   <= '0;
            r_fps       <= '0;
            r_dt        <= '0;
            r_granted   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_total   <= n_total;
            r_frames  <= n_frames;
            r_accum   <= n_accum;
            r_wticks  <= n_wticks;
            r_wframes <= n_wframes;
            r_fps     <= n_fps;
            r_dt      <= n_dt;
            r_granted <= n_granted;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COUNTER_HZ: r_hz        <= i_cfg_data;
                    CFG_FIXED_STEP: r_fixed     <= i_cfg_data;
                    CFG_TIME_SCALE: r_scale     <= i_cfg_data[SCALE_W-1:0];
                    CFG_MAX_DT:     r_max_dt    <= i_cfg_data;
                    CFG_MAX_STEPS:  r_max_steps <= i_cfg_data[STEPS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_stamp <= n_stamp;
        r_prod  <= n_prod;
        r_cap   <= n_cap;
        r_rem   <= n_rem;
        r_dq    <= n_dq;
        r_cnt   <= n_cnt;
    end

    assign o_frame_dt_ticks = r_dt;
    assign o_total_ticks    = r_total;
    assign o_frame_number   = r_frames;
    assign o_fps_value      = r_fps;
    assign o_step_granted   = r_granted;

    // Only one item is ever in flight.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a result item is pending");

    // The accumulator never exceeds the step cap after a tick adds to it.
    a_accum_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |=> (r_accum <= ACC_W'(r_cap)))
        else $error("step accumulator above its cap");

    // The partial remainder stays below the divisor throughout the division.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < w_divisor))
        else $error("divider remainder out of range");

    // A granted step comes only from a consume, which carries no frame delta.
    a_grant_no_dt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_step_granted) |-> (o_frame_dt_ticks == '0))
        else $error("step granted on an item with a frame delta");

endmodule
